[design/bse_pkg.sv]
// Shared types and constants for the bounded stack engine.
package bse_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   typedef enum logic [2:0] {
      KIND_PUSH = 3'd0,
      KIND_DUMP = 3'd1,
      KIND_PEEK = 3'd2,
      KIND_POP  = 3'd3,
      KIND_SWAP = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_DONE  = 3'd0,
      ST_DATA  = 3'd1,
      ST_EMPTY = 3'd2,
      ST_SHORT = 3'd3,
      ST_OVER  = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]              kind;
      logic signed [VAL_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [VAL_W-1:0] out_value;
      logic                    last;
   } rsp_type;

   // Move command broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
      logic swap;
      logic rot;
   } cell_ctl_type;

   // Position of one cell within the live part of the chain.
   typedef struct packed {
      logic is_top;
      logic is_second;
      logic is_tail;
   } cell_role_type;

endpackage

[design/bse_cell.sv]
// One stack entry: holds a word and loads it from a neighbor or the top.
module bse_cell (
   input  logic                                clock,
   input  bse_pkg::cell_ctl_type               ctl,
   input  bse_pkg::cell_role_type              role,
   input  logic signed [bse_pkg::VAL_W-1:0]    above_value,
   input  logic signed [bse_pkg::VAL_W-1:0]    below_value,
   input  logic signed [bse_pkg::VAL_W-1:0]    head_value,
   output logic signed [bse_pkg::VAL_W-1:0]    value
);

   logic signed [bse_pkg::VAL_W-1:0] value_ff;
   logic signed [bse_pkg::VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.push) begin
         value_in = above_value;
      end else if (ctl.pop) begin
         value_in = below_value;
      end else if (ctl.swap) begin
         if (role.is_top) begin
            value_in = below_value;
         end else if (role.is_second) begin
            value_in = above_value;
         end
      end else if (ctl.rot) begin
         // the deepest live entry wraps around to take the old top
         value_in = role.is_tail ? head_value : below_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[design/bounded_stack_engine_core.sv]
// Top level of the bounded stack engine: control, count and the chain of cells.
//
// A LIFO stack of signed 32-bit words built as a shifting chain of cells;
// cell 0 always holds the top of the stack.
// Request channel (req_valid/req_ready/req_data): one operation per word,
// push, dump, peek, pop or swap; push_value matters only for a push.
// Response channel (rsp_valid/rsp_ready/rsp_data): status, out_value and last.
// Push, pop, peek, swap and unused codes give one response word, in the cycle
// after acceptance, and a new request is taken every cycle while the response
// register drains. Push and pop shift the whole chain by one cell; swap
// exchanges cells 0 and 1.
// A dump of n entries starts with the request; then, for each entry, the live
// part of the chain rotates by one cell and the old top goes out. After n
// rotations the stack is back in its original order.
// No request is accepted during a dump. An empty dump gives one empty word.
// Errors (empty, too short, overflow) leave the stack unchanged.
// Reset clears the entry count and the dump state; cell contents are not
// cleared and are never read before they are written.
// A stalled receiver holds the response register and blocks new requests and
// dump rotation until the word is taken.
module bounded_stack_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bse_pkg::rsp_type rsp_data
);

   localparam int DEPTH = bse_pkg::DEPTH;
   localparam int CNT_W = bse_pkg::CNT_W;
   localparam int VAL_W = bse_pkg::VAL_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] dump_left_ff, dump_left_in;
   logic             dump_active_ff, dump_active_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bse_pkg::rsp_type rsp_data_ff, rsp_data_in;

   bse_pkg::cell_ctl_type ctl;
   logic                  emit;
   logic                  slot_free;
   logic                  accept;

   logic signed [VAL_W-1:0] cell_value [DEPTH];

   // response register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !dump_active_ff && slot_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      count_in       = count_ff;
      dump_left_in   = dump_left_ff;
      dump_active_in = dump_active_ff;
      ctl            = '0;
      emit           = 1'b0;
      rsp_data_in    = rsp_data_ff;

      if (dump_active_ff) begin
         if (slot_free) begin
            // send the current top and rotate the live entries by one
            emit                  = 1'b1;
            ctl.rot               = 1'b1;
            rsp_data_in.status    = bse_pkg::ST_DATA;
            rsp_data_in.out_value = cell_value[0];
            rsp_data_in.last      = (dump_left_ff == CNT_W'(1));
            dump_left_in          = dump_left_ff - CNT_W'(1);
            if (dump_left_ff == CNT_W'(1)) begin
               dump_active_in = 1'b0;
            end
         end
      end else if (accept) begin
         emit                  = 1'b1;
         rsp_data_in.status    = bse_pkg::ST_DONE;
         rsp_data_in.out_value = '0;
         rsp_data_in.last      = 1'b1;
         case (req_data.kind)
            bse_pkg::KIND_PUSH: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_data_in.status = bse_pkg::ST_OVER;
               end else begin
                  ctl.push = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            bse_pkg::KIND_DUMP: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = bse_pkg::ST_EMPTY;
               end else begin
                  // hold off the response; the walk produces the words
                  emit           = 1'b0;
                  dump_active_in = 1'b1;
                  dump_left_in   = count_ff;
               end
            end
            bse_pkg::KIND_PEEK: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = bse_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in.status    = bse_pkg::ST_DATA;
                  rsp_data_in.out_value = cell_value[0];
               end
            end
            bse_pkg::KIND_POP: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = bse_pkg::ST_EMPTY;
               end else begin
                  ctl.pop  = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            bse_pkg::KIND_SWAP: begin
               if (count_ff < CNT_W'(2)) begin
                  rsp_data_in.status = bse_pkg::ST_SHORT;
               end else begin
                  ctl.swap = 1'b1;
               end
            end
            default: begin
               // unused codes: done, stack untouched
               rsp_data_in.status = bse_pkg::ST_DONE;
            end
         endcase
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         dump_left_ff   <= '0;
         dump_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         dump_left_ff   <= dump_left_in;
         dump_active_ff <= dump_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // chain of cells, cell 0 on top
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bse_pkg::cell_role_type  role;
      logic signed [VAL_W-1:0] above_value;
      logic signed [VAL_W-1:0] below_value;

      assign role.is_top    = (i == 0);
      assign role.is_second = (i == 1);
      assign role.is_tail   = (count_ff == CNT_W'(i + 1));

      if (i == 0) begin : g_head
         assign above_value = req_data.push_value;
      end else begin : g_body
         assign above_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign below_value = '0;
      end else begin : g_mid
         assign below_value = cell_value[i+1];
      end

      bse_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .role        (role),
         .above_value (above_value),
         .below_value (below_value),
         .head_value  (cell_value[0]),
         .value       (cell_value[i])
      );
   end

endmodule

[dv/bse_checker.sv]
// Stack engine checker: predicts response words from accepted requests and compares them.
module bse_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  bse_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bse_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   logic signed [bse_pkg::VAL_W-1:0] lifo_image [bse_pkg::DEPTH];
   int                               lifo_depth;
   bse_pkg::rsp_type                 due_words [$];

   function automatic bse_pkg::rsp_type make_word(input logic [2:0] st,
                                                  input logic signed [bse_pkg::VAL_W-1:0] v,
                                                  input logic lst);
      bse_pkg::rsp_type w;
      w.status    = st;
      w.out_value = v;
      w.last      = lst;
      return w;
   endfunction

   // Advance the stack image by one operation and queue the words it causes.
   task automatic apply_op(input bse_pkg::req_type op);
      logic signed [bse_pkg::VAL_W-1:0] held;
      case (op.kind)
         bse_pkg::KIND_PUSH: begin
            if (lifo_depth >= bse_pkg::DEPTH) begin
               due_words.push_back(make_word(bse_pkg::ST_OVER, '0, 1'b1));
            end else begin
               lifo_image[lifo_depth] = op.push_value;
               lifo_depth++;
               due_words.push_back(make_word(bse_pkg::ST_DONE, '0, 1'b1));
            end
         end
         bse_pkg::KIND_DUMP: begin
            if (lifo_depth == 0) begin
               due_words.push_back(make_word(bse_pkg::ST_EMPTY, '0, 1'b1));
            end else begin
               for (int k = 0; k < lifo_depth; k++)
                  due_words.push_back(make_word(bse_pkg::ST_DATA,
                                                lifo_image[lifo_depth - 1 - k],
                                                k == lifo_depth - 1));
            end
         end
         bse_pkg::KIND_PEEK: begin
            if (lifo_depth == 0)
               due_words.push_back(make_word(bse_pkg::ST_EMPTY, '0, 1'b1));
            else
               due_words.push_back(make_word(bse_pkg::ST_DATA,
                                             lifo_image[lifo_depth - 1], 1'b1));
         end
         bse_pkg::KIND_POP: begin
            if (lifo_depth == 0) begin
               due_words.push_back(make_word(bse_pkg::ST_EMPTY, '0, 1'b1));
            end else begin
               lifo_depth--;
               due_words.push_back(make_word(bse_pkg::ST_DONE, '0, 1'b1));
            end
         end
         bse_pkg::KIND_SWAP: begin
            if (lifo_depth < 2) begin
               due_words.push_back(make_word(bse_pkg::ST_SHORT, '0, 1'b1));
            end else begin
               held                       = lifo_image[lifo_depth - 1];
               lifo_image[lifo_depth - 1] = lifo_image[lifo_depth - 2];
               lifo_image[lifo_depth - 2] = held;
               due_words.push_back(make_word(bse_pkg::ST_DONE, '0, 1'b1));
            end
         end
         default: due_words.push_back(make_word(bse_pkg::ST_DONE, '0, 1'b1));
      endcase
   endtask

   always @(posedge clock) begin
      bse_pkg::rsp_type want;
      if (reset) begin
         lifo_depth = 0;
         mismatches = 0;
         due_words.delete();
      end else begin
         if (req_valid && req_ready)
            apply_op(req_data);
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected rsp word: status %0d value %0d last %0d",
                           $time, rsp_data.status, rsp_data.out_value, rsp_data.last);
            end else begin
               want = due_words.pop_front();
               if (rsp_data.status !== want.status || rsp_data.out_value !== want.out_value
                   || rsp_data.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"%0t: rsp word mismatch: expected status %0d value %0d last %0d,",
                               " got status %0d value %0d last %0d"},
                              $time, want.status, want.out_value, want.last,
                              rsp_data.status, rsp_data.out_value, rsp_data.last);
               end
            end
         end
      end
      words_due = due_words.size();
   end

endmodule

[dv/tb_top.sv]
// Testbench top for the bounded stack engine: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes beyond swap are spare; the engine must answer them with a plain done word.
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   localparam int RANDOM_ITEMS = 140;
   localparam int FILL_AT      = 40;   // random item index where the stack is driven full
   localparam int HOLD_AT      = 90;   // random item index where the sender waits for drain
   localparam int SETTLE_AT    = 110;  // from here on neither side idles
   localparam int TAIL_CYCLES  = 16;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   bse_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   bse_pkg::rsp_type rsp_data;
   int               mismatches;
   int               words_due;

   // Rough fill level, kept only to steer the random mix toward full and empty.
   int      fill_level;
   logic    settle_phase;

   bounded_stack_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bse_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   initial begin
      #3_200_000;
      $display("bounded_stack_engine_core verification failed");
      $finish;
   end

   // Receiver: drop ready in random bursts, then hold it high for a random stretch.
   // Once the run settles, keep ready high for good.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!settle_phase && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
   end

   // Mostly random 32-bit words, with the extremes, zero and all-ones mixed in now and then.
   function automatic logic signed [bse_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // Favor pushes on a shallow stack and pops on a deep one so depth wanders widely.
   function automatic logic [2:0] pick_kind();
      int roll;
      int push_share;
      push_share = (fill_level > 40) ? 25 : 45;
      roll       = $urandom_range(0, 99);
      if (roll < push_share)
         return bse_pkg::KIND_PUSH;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return bse_pkg::KIND_POP;
      if (roll < 60)
         return bse_pkg::KIND_PEEK;
      if (roll < 80)
         return bse_pkg::KIND_SWAP;
      if (roll < 92)
         return bse_pkg::KIND_DUMP;
      return 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
   endfunction

   // Present one request word at the falling edge, maybe after an idle burst,
   // and hold it until the engine takes it. Returns at the next falling edge.
   task automatic issue(input logic [2:0] op_kind,
                        input logic signed [bse_pkg::VAL_W-1:0] op_value);
      if (!settle_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{kind: op_kind, push_value: op_value};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      case (op_kind)
         bse_pkg::KIND_PUSH: if (fill_level < bse_pkg::DEPTH) fill_level++;
         bse_pkg::KIND_POP:  if (fill_level > 0) fill_level--;
         default: ;
      endcase
   endtask

   initial begin
      req_valid    = 1'b0;
      req_data     = '0;
      reset        = 1'b1;
      fill_level   = 0;
      settle_phase = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: dump, peek, pop and swap on an empty stack first.
      issue(bse_pkg::KIND_DUMP, $urandom());
      issue(bse_pkg::KIND_PEEK, $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_SWAP, $urandom());
      // Swap with a single entry is too short.
      issue(bse_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
      issue(bse_pkg::KIND_SWAP, $urandom());
      issue(bse_pkg::KIND_PUSH, 32'sh8000_0000);
      issue(bse_pkg::KIND_PUSH, '0);
      issue(bse_pkg::KIND_PUSH, '1);
      issue(bse_pkg::KIND_PEEK, $urandom());
      issue(bse_pkg::KIND_SWAP, $urandom());
      issue(bse_pkg::KIND_PEEK, $urandom());
      issue(bse_pkg::KIND_DUMP, $urandom());
      // Spare codes must leave the stack alone.
      for (int c = KIND_UNUSED_LO; c <= KIND_UNUSED_HI; c++)
         issue(3'(c), $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_DUMP, $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_POP,  $urandom());
      issue(bse_pkg::KIND_PUSH, 32'shAAAA_AAAA);
      issue(bse_pkg::KIND_PUSH, 32'sh5555_5555);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == FILL_AT) begin
            // Drive the stack full, push past the top, walk all 64 entries, then swap and peek.
            while (fill_level < bse_pkg::DEPTH)
               issue(bse_pkg::KIND_PUSH, pick_value());
            issue(bse_pkg::KIND_PUSH, pick_value());
            issue(bse_pkg::KIND_PUSH, pick_value());
            issue(bse_pkg::KIND_DUMP, $urandom());
            issue(bse_pkg::KIND_SWAP, $urandom());
            issue(bse_pkg::KIND_PEEK, $urandom());
         end
         if (i == HOLD_AT) begin
            // Hold off the sender until every outstanding word has drained.
            req_valid <= 1'b0;
            wait (words_due == 0);
            @(negedge clock);
         end
         if (i == SETTLE_AT)
            settle_phase = 1'b1;
         issue(pick_kind(), pick_value());
      end
      req_valid <= 1'b0;

      wait (words_due == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && words_due == 0)
         $display("bounded_stack_engine_core verification clean");
      else
         $display("bounded_stack_engine_core verification failed");
      $finish;
   end

endmodule

[filelist.f]
design/bse_pkg.sv
design/bse_cell.sv
design/bounded_stack_engine_core.sv
dv/bse_checker.sv
dv/tb_top.sv
